// ----- design/bus_util_mshr_throttle_assert.svh -----
// Assertion macros for the bus utilization MSHR throttle.
`ifndef BUS_UTIL_MSHR_THROTTLE_ASSERT_SVH
`define BUS_UTIL_MSHR_THROTTLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BUMT_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("bumt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BUMT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("bumt assertion failed");

`endif

// ----- design/bumt_pkg.sv -----
// Shared types and constants for the bus utilization MSHR throttle.
package bumt_pkg;

    localparam int UTIL_W    = 11;
    localparam int USE_W     = 16;
    localparam int CNT_W     = 7;
    localparam int REP_W     = 4;
    localparam int TGT_W     = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 11;
    localparam int NUM_IN_CPUS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDED_REPEATS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSHRS      = 4'd3;

    localparam logic [UTIL_W-1:0] HIGH_THRESHOLD_RST = 11'd870;
    localparam logic [UTIL_W-1:0] LOW_THRESHOLD_RST  = 11'd512;
    localparam logic [REP_W-1:0]  NEEDED_REPEATS_RST = 4'd1;
    localparam logic [CNT_W-1:0]  MAX_MSHRS_RST      = 7'd16;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_DEC  = 2'd1,
        ACT_INC  = 2'd2
    } bumt_action_t;

    typedef struct packed {
        bumt_action_t       action;
        logic [TGT_W-1:0]   target_cpu;
        logic [CNT_W-1:0]   new_count;
    } bumt_result_t;

    typedef struct packed {
        logic [UTIL_W-1:0] high_threshold;
        logic [UTIL_W-1:0] low_threshold;
        logic [REP_W-1:0]  needed_repeats;
        logic [CNT_W-1:0]  max_mshrs;
    } bumt_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [REP_W-1:0] repeats;
    } bumt_cand_t;

endpackage

// ----- design/bumt_decide.sv -----
// Per-sample decision logic: busiest-CPU decrement and smallest-count increment.
module bumt_decide import bumt_pkg::*; #(
    parameter int NUM_CPUS = 4,
    parameter int IDX_W    = 2
) (
    input  logic [UTIL_W-1:0] util,
    input  logic [USE_W-1:0]  use_cnt [NUM_CPUS],
    input  logic [CNT_W-1:0]  cnt [NUM_CPUS],
    input  bumt_cand_t        cand,
    input  logic [IDX_W-1:0]  cand_cpu,
    input  bumt_cfg_t         cfg,
    output logic [CNT_W-1:0]  cnt_next [NUM_CPUS],
    output bumt_cand_t        cand_next,
    output logic [IDX_W-1:0]  cand_cpu_next,
    output bumt_result_t      res0,
    output bumt_result_t      res1,
    output logic              two
);

    function automatic logic [TGT_W-1:0] to_target(input logic [IDX_W-1:0] idx);
        logic [IDX_W+TGT_W-1:0] wide;
        wide = {{TGT_W{1'b0}}, idx};
        return wide[TGT_W-1:0];
    endfunction

    logic              high;
    logic              low;
    logic              found;
    logic [IDX_W-1:0]  best;
    logic [USE_W-1:0]  largest;
    logic              match;
    logic [REP_W-1:0]  rep_inc;
    logic              dec;
    logic              inc;
    logic [CNT_W-1:0]  dec_val;
    logic [CNT_W-1:0]  small_val;
    logic [IDX_W-1:0]  small_idx;
    logic [CNT_W-1:0]  cnt_mid [NUM_CPUS];
    bumt_cand_t        cand_mid;
    logic [IDX_W-1:0]  cpu_mid;
    bumt_result_t      dec_res;
    bumt_result_t      inc_res;
    bumt_result_t      none_res;

    always_comb
    begin
        high = util >= cfg.high_threshold;
        low  = util <= cfg.low_threshold;

        // busiest CPU that can still give up an MSHR, lowest index on ties
        found   = 1'b0;
        best    = '0;
        largest = '0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            if (use_cnt[i] > largest && cnt[i] > CNT_W'(1))
            begin
                largest = use_cnt[i];
                best    = IDX_W'(i);
                found   = 1'b1;
            end
        end

        match    = cand.valid && (cand_cpu == best);
        rep_inc  = cand.repeats + REP_W'(1);
        dec      = 1'b0;
        cand_mid = cand;
        cpu_mid  = cand_cpu;
        if (high && found)
        begin
            if (match)
            begin
                cand_mid.repeats = rep_inc;
                dec = rep_inc >= cfg.needed_repeats;
            end
            else
            begin
                cand_mid.valid   = 1'b1;
                cand_mid.repeats = REP_W'(1);
                cpu_mid          = best;
                dec = cfg.needed_repeats == REP_W'(1);
            end
            if (dec)
                cand_mid.repeats = '0;
        end

        dec_val = cnt[best] - CNT_W'(1);
        cnt_mid = cnt;
        if (dec)
            cnt_mid[best] = dec_val;

        // smallest count after any decrement, lowest index on ties
        small_val = cnt_mid[0];
        small_idx = '0;
        for (int i = 1; i < NUM_CPUS; i++)
        begin
            if (cnt_mid[i] < small_val)
            begin
                small_val = cnt_mid[i];
                small_idx = IDX_W'(i);
            end
        end
        inc = low && (small_val < cfg.max_mshrs);

        cnt_next      = cnt_mid;
        cand_next     = cand_mid;
        cand_cpu_next = cpu_mid;
        if (inc)
        begin
            cnt_next[small_idx] = small_val + CNT_W'(1);
            cand_next           = '0;
            cand_cpu_next       = '0;
        end
        if (!high)
        begin
            cand_next     = '0;
            cand_cpu_next = '0;
        end

        dec_res.action     = ACT_DEC;
        dec_res.target_cpu = to_target(best);
        dec_res.new_count  = dec_val;
        inc_res.action     = ACT_INC;
        inc_res.target_cpu = to_target(small_idx);
        inc_res.new_count  = small_val + CNT_W'(1);
        none_res.action     = ACT_NONE;
        none_res.target_cpu = '0;
        none_res.new_count  = '0;

        res1 = inc_res;
        two  = 1'b0;
        if (dec)
        begin
            res0 = dec_res;
            two  = inc;
        end
        else if (inc)
            res0 = inc_res;
        else
            res0 = none_res;
    end

endmodule

// ----- design/bumt_outq.sv -----
// Two-entry result queue that serializes the beats of one sample.
module bumt_outq import bumt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  bumt_result_t res0,
    input  bumt_result_t res1,
    input  logic         two,
    input  logic         out_ready,
    output logic         out_valid,
    output bumt_result_t head,
    output logic         head_last,
    output logic         can_load
);

    logic [1:0]   cnt_reg;
    bumt_result_t r0_reg;
    bumt_result_t r1_reg;

    assign out_valid = cnt_reg != 2'd0;
    assign head      = r0_reg;
    assign head_last = cnt_reg == 2'd1;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= two ? 2'd2 : 2'd1;
        else if (out_valid && out_ready)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r0_reg <= res0;
            r1_reg <= res1;
        end
        else if (out_valid && out_ready)
            r0_reg <= r1_reg;
    end

endmodule

// ----- design/bus_util_mshr_throttle.sv -----
// Top level of the bus utilization driven MSHR throttle.
//
// Each input beat is one sample period: data bus utilization (Q1.10) and
// the data bus use count of each CPU. The block keeps an MSHR count per
// CPU data cache and answers each sample with one or two result beats:
// a decrement of the busiest eligible CPU, an increment of the CPU with
// the fewest MSHRs, or a single no-change beat. The final beat of a
// sample carries last; a decrement always comes before an increment.
// A sample is captured in the input register, decided combinationally
// from it, and its result beats are loaded into the result queue.
// One sample per cycle is taken while each sample gives one beat and
// the receiver is ready; a two-beat sample holds the two-entry result
// queue until both drain. The limit is the output port, one beat per cycle.
// When the receiver stalls, the result queue holds its beats, the input
// register holds the next sample, and in_ready drops once both are full.
// The configuration channel is always ready; writing max_mshrs reloads
// every MSHR count with the new value. Reset restores the register
// defaults, loads all counts with the default max, clears the candidate.
module bus_util_mshr_throttle import bumt_pkg::*; #(
    parameter int NUM_CPUS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [UTIL_W-1:0]    data_util,
    input  logic [USE_W-1:0]     use_cpu0,
    input  logic [USE_W-1:0]     use_cpu1,
    input  logic [USE_W-1:0]     use_cpu2,
    input  logic [USE_W-1:0]     use_cpu3,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           action,
    output logic [TGT_W-1:0]     target_cpu,
    output logic [CNT_W-1:0]     new_count,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    `include "bus_util_mshr_throttle_assert.svh"

    localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    // input register
    logic              in_valid_reg;
    logic [UTIL_W-1:0] util_reg;
    logic [USE_W-1:0]  use_reg [NUM_IN_CPUS];
    logic [USE_W-1:0]  use_port [NUM_IN_CPUS];
    logic [USE_W-1:0]  use_cnt [NUM_CPUS];

    // configuration and throttle state
    bumt_cfg_t         cfg_reg;
    logic [CNT_W-1:0]  cnt_reg [NUM_CPUS];
    logic [CNT_W-1:0]  cnt_next [NUM_CPUS];
    bumt_cand_t        cand_reg;
    bumt_cand_t        cand_next;
    logic [IDX_W-1:0]  cand_cpu_reg;
    logic [IDX_W-1:0]  cand_cpu_next;

    // decision and result queue
    bumt_result_t      res0;
    bumt_result_t      res1;
    bumt_result_t      head;
    logic              two;
    logic              can_load;
    logic              advance;
    logic              cfg_write;

    assign use_port[0] = use_cpu0;
    assign use_port[1] = use_cpu1;
    assign use_port[2] = use_cpu2;
    assign use_port[3] = use_cpu3;

    // CPUs beyond the four input ports see zero use
    for (genvar g = 0; g < NUM_CPUS; g++)
    begin : g_use
        if (g < NUM_IN_CPUS)
        begin : g_port
            assign use_cnt[g] = use_reg[g];
        end
        else
        begin : g_zero
            assign use_cnt[g] = '0;
        end
    end

    // advance the held sample into the result queue when the queue frees up
    assign advance   = in_valid_reg && can_load;
    assign in_ready  = !in_valid_reg || can_load;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            util_reg <= data_util;
            use_reg  <= use_port;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold <= HIGH_THRESHOLD_RST;
            cfg_reg.low_threshold  <= LOW_THRESHOLD_RST;
            cfg_reg.needed_repeats <= NEEDED_REPEATS_RST;
            cfg_reg.max_mshrs      <= MAX_MSHRS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HIGH_THRESHOLD: cfg_reg.high_threshold <= cfg_data[UTIL_W-1:0];
                CFG_LOW_THRESHOLD:  cfg_reg.low_threshold  <= cfg_data[UTIL_W-1:0];
                CFG_NEEDED_REPEATS: cfg_reg.needed_repeats <= cfg_data[REP_W-1:0];
                CFG_MAX_MSHRS:      cfg_reg.max_mshrs      <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // MSHR counts and candidate; a max_mshrs write reloads every count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
                cnt_reg[i] <= MAX_MSHRS_RST;
            cand_reg     <= '0;
            cand_cpu_reg <= '0;
        end
        else if (cfg_write && cfg_index == CFG_MAX_MSHRS)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
                cnt_reg[i] <= cfg_data[CNT_W-1:0];
        end
        else if (advance)
        begin
            cnt_reg      <= cnt_next;
            cand_reg     <= cand_next;
            cand_cpu_reg <= cand_cpu_next;
        end
    end

    bumt_decide #(
        .NUM_CPUS (NUM_CPUS),
        .IDX_W    (IDX_W)
    ) u_decide (
        .util          (util_reg),
        .use_cnt       (use_cnt),
        .cnt           (cnt_reg),
        .cand          (cand_reg),
        .cand_cpu      (cand_cpu_reg),
        .cfg           (cfg_reg),
        .cnt_next      (cnt_next),
        .cand_next     (cand_next),
        .cand_cpu_next (cand_cpu_next),
        .res0          (res0),
        .res1          (res1),
        .two           (two)
    );

    bumt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res0      (res0),
        .res1      (res1),
        .two       (two),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .head_last (last),
        .can_load  (can_load)
    );

    assign action     = head.action;
    assign target_cpu = head.target_cpu;
    assign new_count  = head.new_count;

    // a sample moved into the queue shows a beat in the next cycle
    `BUMT_ASSERT_NEXT(a_load_shows_beat, clk, rst_n, advance, out_valid)
    // a blocked sample stays in the input register unchanged
    `BUMT_ASSERT_NEXT(a_hold_sample, clk, rst_n, in_valid_reg && !advance,
                      in_valid_reg && $stable(util_reg))
    // draining the final beat with nothing behind it empties the output
    `BUMT_ASSERT_NEXT(a_last_drains, clk, rst_n,
                      out_valid && out_ready && last && !advance, !out_valid)
    // the first of two beats is always the decrement
    `BUMT_ASSERT_SAME(a_first_is_dec, clk, rst_n, out_valid && !last, action == ACT_DEC)

endmodule

// ----- tb/bus_util_mshr_throttle_tb.sv -----
// Self-checking testbench for the bus utilization MSHR throttle.
module bus_util_mshr_throttle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bumt_pkg::*;

    // Stimulus size and run bounds.
    localparam int RANDOM_SAMPLES = 1850;
    localparam int PHASES         = 7;
    localparam int PRESSURE_ITEMS = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SHOWN_ERRORS   = 10;

    // Register indexes the block ignores.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 4'd15;

    // Register select masks for set_regs.
    localparam logic [15:0] SEL_HIGH  = 16'd1 << CFG_HIGH_THRESHOLD;
    localparam logic [15:0] SEL_LOW   = 16'd1 << CFG_LOW_THRESHOLD;
    localparam logic [15:0] SEL_REP   = 16'd1 << CFG_NEEDED_REPEATS;
    localparam logic [15:0] SEL_MAX   = 16'd1 << CFG_MAX_MSHRS;
    localparam logic [15:0] SEL_ALL   = SEL_HIGH | SEL_LOW | SEL_REP | SEL_MAX;
    localparam logic [15:0] SEL_SPARE = (16'd1 << CFG_SPARE_FIRST) | (16'd1 << CFG_SPARE_LAST);

    // Receiver stall patterns.
    localparam int RX_FLOW   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_MOSTLY = 2;
    localparam int RX_SPARSE = 3;

    // One result beat as the block should present it.
    typedef struct packed {
        bumt_action_t     act;
        logic [TGT_W-1:0] cpu;
        logic [CNT_W-1:0] cnt;
        logic             fin;
    } mshr_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 in_valid;
    logic                 in_ready;
    logic [UTIL_W-1:0]    data_util;
    logic [USE_W-1:0]     use_cpu0;
    logic [USE_W-1:0]     use_cpu1;
    logic [USE_W-1:0]     use_cpu2;
    logic [USE_W-1:0]     use_cpu3;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           action;
    logic [TGT_W-1:0]     target_cpu;
    logic [CNT_W-1:0]     new_count;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Throttle state and registers as the block should hold them.
    logic [UTIL_W-1:0] thr_high;
    logic [UTIL_W-1:0] thr_low;
    logic [REP_W-1:0]  rep_need;
    logic [CNT_W-1:0]  mshr_max;
    logic [CNT_W-1:0]  mshr_cnt [NUM_IN_CPUS];
    logic              cand_vld;
    logic [TGT_W-1:0]  cand_id;
    logic [REP_W-1:0]  rep_cnt;

    // Beats predicted but not yet seen on the output, oldest first.
    mshr_beat_t beats_due [$];

    int fail_count;
    int samples_sent;
    int reg_writes;
    int settings_used;
    int dec_beats;
    int inc_beats;
    int none_beats;
    int longest_in_stall;

    // Sender burst control.
    bit sender_gaps;
    int burst_left;

    // Random sample shaping: one CPU stays the heavy user for a run of samples.
    int favored;
    int run_left;

    // Long receiver hold requested by a test, served by the receiver process.
    int hold_id;
    int hold_len;
    int hold_seen;
    int hold_left;
    int rx_mode;
    int mode_left;

    bus_util_mshr_throttle uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_util  (data_util),
        .use_cpu0   (use_cpu0),
        .use_cpu1   (use_cpu1),
        .use_cpu2   (use_cpu2),
        .use_cpu3   (use_cpu3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .action     (action),
        .target_cpu (target_cpu),
        .new_count  (new_count),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Throttle prediction
    // ------------------------------------------------------------------

    function automatic void throttle_reset();
        thr_high = HIGH_THRESHOLD_RST;
        thr_low  = LOW_THRESHOLD_RST;
        rep_need = NEEDED_REPEATS_RST;
        mshr_max = MAX_MSHRS_RST;
        for (int i = 0; i < NUM_IN_CPUS; i++)
        begin
            mshr_cnt[i] = MAX_MSHRS_RST;
        end
        cand_vld = 1'b0;
        cand_id  = '0;
        rep_cnt  = '0;
    endfunction

    // Writing max_mshrs refills every cache; unknown indexes change nothing.
    function automatic void throttle_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DAT_W-1:0] val);
        case (idx)
            CFG_HIGH_THRESHOLD: thr_high = val[UTIL_W-1:0];
            CFG_LOW_THRESHOLD:  thr_low  = val[UTIL_W-1:0];
            CFG_NEEDED_REPEATS: rep_need = val[REP_W-1:0];
            CFG_MAX_MSHRS:
            begin
                mshr_max = val[CNT_W-1:0];
                for (int i = 0; i < NUM_IN_CPUS; i++)
                begin
                    mshr_cnt[i] = mshr_max;
                end
            end
            default: ;
        endcase
    endfunction

    // Decide one sample period and queue the beats it should produce.
    function automatic void throttle_decide(input logic [UTIL_W-1:0] util,
                                            input logic [USE_W-1:0] u0,
                                            input logic [USE_W-1:0] u1,
                                            input logic [USE_W-1:0] u2,
                                            input logic [USE_W-1:0] u3);
        logic [USE_W-1:0] use_of [NUM_IN_CPUS];
        mshr_beat_t       made [2];
        int               n;
        int               best;
        int               low_idx;
        logic [USE_W-1:0] largest;
        logic [CNT_W-1:0] smallest;
        logic             busy;
        logic             dec;

        use_of[0] = u0;
        use_of[1] = u1;
        use_of[2] = u2;
        use_of[3] = u3;
        n    = 0;
        busy = (util >= thr_high);

        // Busy bus: pick the heaviest user that can still give up an MSHR.
        if (busy)
        begin
            best    = -1;
            largest = '0;
            for (int i = 0; i < NUM_IN_CPUS; i++)
            begin
                if (use_of[i] > largest && mshr_cnt[i] > 1)
                begin
                    largest = use_of[i];
                    best    = i;
                end
            end
            if (best >= 0)
            begin
                dec = 1'b0;
                if (cand_vld && cand_id == best[TGT_W-1:0])
                begin
                    rep_cnt = rep_cnt + 1'b1;
                    dec     = (rep_cnt >= rep_need);
                end
                else
                begin
                    cand_vld = 1'b1;
                    cand_id  = best[TGT_W-1:0];
                    rep_cnt  = REP_W'(1);
                    dec      = (rep_need == 1);
                end
                if (dec)
                begin
                    mshr_cnt[best] = mshr_cnt[best] - 1'b1;
                    rep_cnt        = '0;
                    made[n]        = '{ACT_DEC, best[TGT_W-1:0], mshr_cnt[best], 1'b0};
                    n++;
                end
            end
        end

        // Quiet bus: give one MSHR back to the smallest cache unless saturated.
        if (util <= thr_low)
        begin
            low_idx  = 0;
            smallest = mshr_cnt[0];
            for (int i = 1; i < NUM_IN_CPUS; i++)
            begin
                if (mshr_cnt[i] < smallest)
                begin
                    smallest = mshr_cnt[i];
                    low_idx  = i;
                end
            end
            if (smallest < mshr_max)
            begin
                cand_vld          = 1'b0;
                cand_id           = '0;
                rep_cnt           = '0;
                mshr_cnt[low_idx] = mshr_cnt[low_idx] + 1'b1;
                made[n] = '{ACT_INC, low_idx[TGT_W-1:0], mshr_cnt[low_idx], 1'b0};
                n++;
            end
        end

        if (!busy)
        begin
            cand_vld = 1'b0;
            cand_id  = '0;
            rep_cnt  = '0;
        end

        if (n == 0)
        begin
            made[0] = '{ACT_NONE, '0, '0, 1'b0};
            n = 1;
        end
        made[n-1].fin = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            beats_due.push_back(made[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_beat(input string what, input mshr_beat_t want);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
        begin
            $display("%0t: %s: expected action %0d cpu %0d count %0d last %0d,",
                     $realtime, what, want.act, want.cpu, want.cnt, want.fin);
            $display("    got action %0d cpu %0d count %0d last %0d",
                     action, target_cpu, new_count, last);
        end
    endtask

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        mshr_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            case (action)
                ACT_DEC: dec_beats++;
                ACT_INC: inc_beats++;
                default: none_beats++;
            endcase
            if (beats_due.size() == 0)
            begin
                report_beat("unexpected beat", '0);
            end
            else
            begin
                want = beats_due.pop_front();
                if (action !== want.act || target_cpu !== want.cpu ||
                    new_count !== want.cnt || last !== want.fin)
                begin
                    report_beat("beat mismatch", want);
                end
            end
        end
    end

    // Receiver: serve a long hold when asked, otherwise stall on a changing pattern.
    always @(posedge clk)
    begin
        if (hold_seen != hold_id)
        begin
            hold_seen = hold_id;
            hold_left = hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(RX_SPARSE, RX_FLOW);
                mode_left = $urandom_range(256, 32);
            end
            mode_left--;
            case (rx_mode)
                RX_FLOW:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
                RX_MOSTLY: out_ready <= ($urandom_range(9, 0) != 0);
                default:   out_ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one sample, hold it until accepted, then predict its beats.
    // Valid stays high afterwards so back-to-back samples never drop it.
    task automatic send_sample(input logic [UTIL_W-1:0] util,
                               input logic [USE_W-1:0] u0,
                               input logic [USE_W-1:0] u1,
                               input logic [USE_W-1:0] u2,
                               input logic [USE_W-1:0] u3);
        int stall;
        stall = 0;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
                burst_left = $urandom_range(24, 1);
            end
            burst_left--;
        end
        in_valid  <= 1'b1;
        data_util <= util;
        use_cpu0  <= u0;
        use_cpu1  <= u1;
        use_cpu2  <= u2;
        use_cpu3  <= u3;
        @(posedge clk);
        while (!in_ready)
        begin
            stall++;
            @(posedge clk);
        end
        if (stall > longest_in_stall)
            longest_in_stall = stall;
        samples_sent++;
        throttle_decide(util, u0, u1, u2, u3);
    endtask

    // Drop valid and let every predicted beat drain, plus the pipeline depth.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the selected registers in index order once the block is idle.
    task automatic set_regs(input logic [15:0] sel,
                            input logic [CFG_DAT_W-1:0] hi,
                            input logic [CFG_DAT_W-1:0] lo,
                            input logic [CFG_DAT_W-1:0] rep,
                            input logic [CFG_DAT_W-1:0] mx,
                            input logic [CFG_DAT_W-1:0] spare);
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        wait_idle();
        for (int i = 0; i < 16; i++)
        begin
            if (sel[i])
            begin
                idx = i[CFG_IDX_W-1:0];
                case (idx)
                    CFG_HIGH_THRESHOLD: val = hi;
                    CFG_LOW_THRESHOLD:  val = lo;
                    CFG_NEEDED_REPEATS: val = rep;
                    CFG_MAX_MSHRS:      val = mx;
                    default:            val = spare;
                endcase
                cfg_valid <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= val;
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
                throttle_reg_write(idx, val);
                reg_writes++;
            end
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Build one random sample. Most are well formed: a utilization band chosen
    // on purpose and one CPU that stays the heavy user across a run, so that
    // candidates repeat and counts walk all the way down and back up.
    task automatic random_sample();
        logic [UTIL_W-1:0] util;
        logic [USE_W-1:0]  u [NUM_IN_CPUS];
        int                kind;
        int                lo_mid;
        int                hi_mid;
        if (run_left == 0)
        begin
            favored  = $urandom_range(NUM_IN_CPUS - 1, 0);
            run_left = $urandom_range(20, 1);
        end
        run_left--;
        kind = $urandom_range(19, 0);
        for (int i = 0; i < NUM_IN_CPUS; i++)
            u[i] = USE_W'($urandom_range(16'h7FFF, 0));
        u[favored] = USE_W'($urandom_range(16'hFFFF, 16'h8000));
        if (kind <= 6)
        begin
            util = UTIL_W'($urandom_range(2047, thr_high));
        end
        else if (kind <= 10)
        begin
            util = UTIL_W'($urandom_range(thr_low, 0));
        end
        else if (kind <= 13)
        begin
            lo_mid = thr_low + 1;
            hi_mid = thr_high - 1;
            if (hi_mid >= lo_mid)
                util = UTIL_W'($urandom_range(hi_mid, lo_mid));
            else
                util = UTIL_W'($urandom_range(2047, 0));
        end
        else if (kind <= 16)
        begin
            // Noise: anything the fields can carry.
            util = UTIL_W'($urandom_range(2047, 0));
            for (int i = 0; i < NUM_IN_CPUS; i++)
                u[i] = USE_W'($urandom_range(16'hFFFF, 0));
        end
        else if (kind == 17)
        begin
            // Tied heavy users.
            util = UTIL_W'($urandom_range(2047, thr_high));
            u[0] = USE_W'($urandom_range(16'hFFFF, 0));
            for (int i = 1; i < NUM_IN_CPUS; i++)
                u[i] = u[0];
        end
        else if (kind == 18)
        begin
            util = UTIL_W'($urandom_range(2047, 0));
            for (int i = 0; i < NUM_IN_CPUS; i++)
                u[i] = '0;
        end
        else
        begin
            // Threshold edges and field extremes.
            case ($urandom_range(6, 0))
                0:       util = '0;
                1:       util = 11'd1024;
                2:       util = 11'd2047;
                3:       util = thr_high;
                4:       util = thr_low;
                5:       util = thr_high - 1'b1;
                default: util = thr_low + 1'b1;
            endcase
        end
        send_sample(util, u[0], u[1], u[2], u[3]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: saturation, ties, exact thresholds, no eligible CPU.
    task automatic test_reset_defaults();
        send_sample(11'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(11'd1024, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(11'd2047, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_sample(11'd870,  16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_sample(11'd869,  16'h0000, 16'h0000, 16'h0005, 16'h0000);
        send_sample(11'd512,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(11'd513,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(11'd1024, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // A candidate must win three busy samples in a row; a new winner restarts.
    task automatic test_repeat_window();
        set_regs(SEL_ALL, 11'd870, 11'd512, 11'd3, 11'd4, '0);
        repeat (4) send_sample(11'd1000, 16'd10, 16'd20, 16'd300, 16'd40);
        repeat (3) send_sample(11'd1000, 16'd10, 16'd500, 16'd300, 16'd40);
    endtask

    // Overlapping thresholds give decrement then increment in one sample;
    // with zero repeats only a repeated candidate decrements.
    task automatic test_overlap_zero_repeats();
        set_regs(SEL_ALL, 11'd600, 11'd700, 11'd0, 11'd3, '0);
        repeat (4) send_sample(11'd650, 16'd0, 16'd0, 16'd0, 16'd9);
        send_sample(11'd2047, 16'd7, 16'd7, 16'd3, 16'd1);
    endtask

    // Count limits: single MSHR caches, zero max, full register width,
    // and writes to indexes the block does not decode.
    task automatic test_count_limits();
        set_regs(SEL_MAX, '0, '0, '0, 11'd1, '0);
        send_sample(11'd1024, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(11'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        set_regs(SEL_MAX, '0, '0, '0, 11'd0, '0);
        send_sample(11'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        set_regs(SEL_MAX, '0, '0, '0, 11'h7FF, '0);
        send_sample(11'd1024, 16'd1, 16'd2, 16'd3, 16'd4);
        send_sample(11'd0,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        set_regs(SEL_SPARE, '0, '0, '0, '0, 11'h7FF);
        send_sample(11'd2047, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0);
    endtask

    // Random samples over several settings, extremes first.
    task automatic test_random_settings();
        logic [CFG_DAT_W-1:0] hi;
        logic [CFG_DAT_W-1:0] lo;
        logic [CFG_DAT_W-1:0] rep;
        logic [CFG_DAT_W-1:0] mx;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    hi = 11'd870;  lo = 11'd512;  rep = 11'd1;  mx = 11'd16;
                end
                1:
                begin
                    hi = 11'd1024; lo = 11'd0;    rep = 11'd15; mx = 11'd64;
                end
                2:
                begin
                    hi = 11'd0;    lo = 11'd0;    rep = 11'd2;  mx = 11'd8;
                end
                3:
                begin
                    hi = 11'd2047; lo = 11'd2047; rep = 11'd0;  mx = 11'd3;
                end
                4:
                begin
                    hi = 11'd700;  lo = 11'd800;  rep = 11'd4;  mx = 11'd2;
                end
                5:
                begin
                    hi  = CFG_DAT_W'($urandom_range(1024, 0));
                    lo  = CFG_DAT_W'($urandom_range(1024, 0));
                    rep = CFG_DAT_W'($urandom_range(15, 1));
                    mx  = CFG_DAT_W'($urandom_range(64, 1));
                end
                default:
                begin
                    hi  = CFG_DAT_W'($urandom_range(2047, 0));
                    lo  = CFG_DAT_W'($urandom_range(2047, 0));
                    rep = CFG_DAT_W'($urandom_range(15, 0));
                    mx  = CFG_DAT_W'($urandom_range(64, 0));
                end
            endcase
            set_regs(SEL_ALL, hi, lo, rep, mx, '0);
            // Run some phases back to back so the input never idles.
            sender_gaps = (p % 3 != 0);
            repeat (RANDOM_SAMPLES / PHASES) random_sample();
        end
        sender_gaps = 1'b1;
    endtask

    // Hold the receiver off while samples keep coming, so the result queue
    // and input register fill and the block must stall its input.
    task automatic test_output_backpressure();
        set_regs(SEL_ALL, 11'd600, 11'd700, 11'd2, 11'd6, '0);
        sender_gaps = 1'b0;
        hold_len    = HOLD_CYCLES;
        hold_id++;
        repeat (PRESSURE_ITEMS) random_sample();
        sender_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_util   = '0;
        use_cpu0    = '0;
        use_cpu1    = '0;
        use_cpu2    = '0;
        use_cpu3    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        sender_gaps = 1'b1;
        throttle_reset();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_repeat_window();
        test_overlap_zero_repeats();
        test_count_limits();
        test_random_settings();
        test_output_backpressure();
        wait_idle();

        $display("Covered %0d samples across %0d register settings (%0d register writes).",
                 samples_sent, settings_used, reg_writes);
        $display("Beats seen: %0d decrement, %0d increment, %0d no change; %s %0d cycles.",
                 dec_beats, inc_beats, none_beats, "longest input stall",
                 longest_in_stall);
        if (fail_count == 0 && beats_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/bumt_pkg.sv
design/bumt_decide.sv
design/bumt_outq.sv
design/bus_util_mshr_throttle.sv
tb/bus_util_mshr_throttle_tb.sv
